### sv/dpq_pkg.sv
package dpq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_REMOVED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic        command;
    logic [15:0] task_tag;
    logic [4:0]  due_day;
    logic [3:0]  due_month;
    logic [13:0] due_year;
    logic [6:0]  difficulty_total;
    logic [3:0]  subtask_count;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [6:0]  out_total;
    logic [3:0]  out_count;
    logic [6:0]  fill_level;
  } result_t;

  // One stored task record, 50 bits.
  typedef struct packed {
    logic [15:0] tag;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [6:0]  total;
    logic [3:0]  count;
  } record_t;

  localparam int REC_W = $bits(record_t);

endpackage

### sv/dpq_mem.sv
module dpq_mem import dpq_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  record_t           wdata,
  input  logic [ADDR_W-1:0] raddr,
  output record_t           rdata
);

  record_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/dpq_order.sv
module dpq_order import dpq_pkg::*; (
  input  record_t new_rec,
  input  record_t old_rec,
  output logic    goes_before
);

  logic [22:0] new_date;
  logic [22:0] old_date;
  logic [10:0] new_cross;
  logic [10:0] old_cross;
  logic        avg_greater;

  assign new_date = {new_rec.year, new_rec.month, new_rec.day};
  assign old_date = {old_rec.year, old_rec.month, old_rec.day};

  // Averages are compared exactly: total_a * count_b against total_b * count_a.
  assign new_cross = 11'(new_rec.total * old_rec.count);
  assign old_cross = 11'(old_rec.total * new_rec.count);

  always_comb begin
    if (new_rec.count == 4'd0) begin
      avg_greater = 1'b0;
    end else if (old_rec.count == 4'd0) begin
      avg_greater = (new_rec.total != 7'd0);
    end else begin
      avg_greater = (new_cross > old_cross);
    end
  end

  assign goes_before = (new_date < old_date) || ((new_date == old_date) && avg_greater);

endmodule

### sv/deadline_priority_task_queue.sv
// Channel    Ports                      Transaction
// request    start, busy, request       taken when start is high and busy is low
// result     done, result               one cycle, marked by done, cannot be held off
//
// Each transaction yields one result. A full insert or an empty removal answers from idle.
// An insert reads and compares each stored record that it moves back, then writes its own
// record; a removal reads the front record, then moves each later record forward one place.
// Both walks go through the record memory, one read and one write per entry.
// Reset (rst, synchronous) empties the queue at once; the memory itself is not cleared.
// The receiver cannot stall, so a finished transaction never waits on the output.
module deadline_priority_task_queue import dpq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_INS_RD    = 3'd1;
  localparam logic [2:0] S_INS_CMP   = 3'd2;
  localparam logic [2:0] S_INS_PUT   = 3'd3;
  localparam logic [2:0] S_REM_RD    = 3'd4;
  localparam logic [2:0] S_REM_FRONT = 3'd5;
  localparam logic [2:0] S_SHF_RD    = 3'd6;
  localparam logic [2:0] S_SHF_WR    = 3'd7;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] pos, pos_next;
  record_t          rec, rec_next;
  record_t          outrec, outrec_next;
  logic [1:0]       status, status_next;
  logic             done_next;

  logic             we;
  logic [CNT_W-1:0] raddr_full;
  record_t          wdata;
  record_t          rdata;
  logic             goes_before;
  logic [31:0]      count_wide;

  dpq_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (pos[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (raddr_full[ADDR_W-1:0]),
    .rdata (rdata)
  );

  dpq_order u_order (
    .new_rec     (rec),
    .old_rec     (rdata),
    .goes_before (goes_before)
  );

  // Memory port control, decoded from the sequencer state, position and order comparison.
  always_comb begin
    we         = 1'b0;
    wdata      = rec;
    raddr_full = '0;
    case (state)
      S_INS_RD: begin
        raddr_full = pos - CNT_W'(1);
      end
      S_INS_CMP: begin
        we    = 1'b1;
        wdata = goes_before ? rdata : rec;
      end
      S_INS_PUT: begin
        we = 1'b1;
      end
      S_SHF_RD: begin
        raddr_full = pos + CNT_W'(1);
      end
      S_SHF_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    pos_next    = pos;
    rec_next    = rec;
    outrec_next = outrec;
    status_next = status;
    done_next   = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          rec_next = '{tag:   request.task_tag,
                       day:   request.due_day,
                       month: request.due_month,
                       year:  request.due_year,
                       total: request.difficulty_total,
                       count: request.subtask_count};
          outrec_next = '0;
          if (request.command == CMD_INSERT) begin
            if (count == CNT_W'(CAPACITY)) begin
              status_next = ST_FULL;
              done_next   = 1'b1;
            end else begin
              pos_next   = count;
              state_next = (count == '0) ? S_INS_PUT : S_INS_RD;
            end
          end else begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              done_next   = 1'b1;
            end else begin
              state_next = S_REM_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (goes_before) begin
          // The stored record has moved back one place; look at the one in front.
          pos_next   = pos - CNT_W'(1);
          state_next = (pos == CNT_W'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          count_next  = count + CNT_W'(1);
          status_next = ST_INSERTED;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_INS_PUT: begin
        count_next  = count + CNT_W'(1);
        status_next = ST_INSERTED;
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end
      S_REM_RD: begin
        state_next = S_REM_FRONT;
      end
      S_REM_FRONT: begin
        outrec_next = rdata;
        pos_next    = '0;
        if (count == CNT_W'(1)) begin
          count_next  = count - CNT_W'(1);
          status_next = ST_REMOVED;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_SHF_RD;
        end
      end
      S_SHF_RD: begin
        state_next = S_SHF_WR;
      end
      S_SHF_WR: begin
        pos_next = pos + CNT_W'(1);
        if (pos + CNT_W'(2) == count) begin
          count_next  = count - CNT_W'(1);
          status_next = ST_REMOVED;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_SHF_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    pos    <= pos_next;
    rec    <= rec_next;
    outrec <= outrec_next;
    status <= status_next;
  end

  assign busy = (state != S_IDLE);

  // The fill level wraps modulo 128 for very large queues.
  assign count_wide = 32'(count);

  assign result = '{status:     status,
                    out_tag:    outrec.tag,
                    out_day:    outrec.day,
                    out_month:  outrec.month,
                    out_year:   outrec.year,
                    out_total:  outrec.total,
                    out_count:  outrec.count,
                    fill_level: count_wide[6:0]};

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dpq_pkg::*;

  localparam int QUEUE_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 550;
  localparam int ROUND_LENGTH  = 80;
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 40;
  localparam int CYCLE_LIMIT   = 500000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  deadline_priority_task_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  request_t pending_requests[$];
  result_t  expected_results[$];
  record_t  sorted_records[$];

  int error_count    = 0;
  int cycle_count    = 0;
  int accepted_count = 0;
  int peak_fill      = 0;
  int status_tally[4] = '{0, 0, 0, 0};

  initial begin
    forever #2 clk = ~clk;
  end

  // Date first, as one unsigned number; on an equal date the harder record
  // goes ahead, with difficulty averages compared by cross-multiplication.
  function automatic bit goes_ahead(record_t a, record_t b);
    logic [22:0] date_a;
    logic [22:0] date_b;
    logic [31:0] lhs;
    logic [31:0] rhs;
    date_a = {a.year, a.month, a.day};
    date_b = {b.year, b.month, b.day};
    if (date_a != date_b) return date_a < date_b;
    if (a.count == 0) return 1'b0;
    if (b.count == 0) return a.total != 0;
    lhs = 32'(a.total) * 32'(b.count);
    rhs = 32'(b.total) * 32'(a.count);
    return lhs > rhs;
  endfunction

  function automatic result_t queue_step(request_t req);
    result_t res;
    record_t rec;
    int      pos;
    res = '0;
    if (req.command == CMD_INSERT) begin
      if (sorted_records.size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        rec.tag   = req.task_tag;
        rec.day   = req.due_day;
        rec.month = req.due_month;
        rec.year  = req.due_year;
        rec.total = req.difficulty_total;
        rec.count = req.subtask_count;
        pos = sorted_records.size();
        while (pos > 0 && goes_ahead(rec, sorted_records[pos - 1])) pos--;
        sorted_records.insert(pos, rec);
        res.status = ST_INSERTED;
      end
    end else if (sorted_records.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      rec = sorted_records.pop_front();
      res.status    = ST_REMOVED;
      res.out_tag   = rec.tag;
      res.out_day   = rec.day;
      res.out_month = rec.month;
      res.out_year  = rec.year;
      res.out_total = rec.total;
      res.out_count = rec.count;
    end
    res.fill_level = 7'(sorted_records.size());
    if (sorted_records.size() > peak_fill) peak_fill = sorted_records.size();
    return res;
  endfunction

  function automatic request_t insert_of(logic [15:0] tag, logic [4:0] day,
                                         logic [3:0] month, logic [13:0] year,
                                         logic [6:0] total, logic [3:0] count);
    request_t req;
    req.command          = CMD_INSERT;
    req.task_tag         = tag;
    req.due_day          = day;
    req.due_month        = month;
    req.due_year         = year;
    req.difficulty_total = total;
    req.subtask_count    = count;
    return req;
  endfunction

  // The payload of a removal is ignored by the block, so it carries noise.
  function automatic request_t removal();
    logic [63:0] raw;
    request_t    req;
    raw = {$urandom, $urandom};
    req = raw[$bits(request_t)-1:0];
    req.command = CMD_REMOVE;
    return req;
  endfunction

  // Most dates come from a narrow window so that equal dates are common.
  function automatic request_t random_insert();
    request_t req;
    logic [3:0] count;
    req = removal();
    req.command = CMD_INSERT;
    if ($urandom_range(0, 99) < 80) begin
      req.due_year  = 14'(2023 + $urandom_range(0, 2));
      req.due_month = 4'($urandom_range(1, 2));
      req.due_day   = 5'($urandom_range(1, 3));
    end else begin
      req.due_year  = 14'($urandom_range(0, 16383));
      req.due_month = 4'($urandom_range(0, 15));
      req.due_day   = 5'($urandom_range(0, 31));
    end
    if ($urandom_range(0, 99) < 85) begin
      count = 4'($urandom_range(0, 10));
      req.subtask_count    = count;
      req.difficulty_total = (count == 0) ? 7'($urandom_range(0, 100))
                                          : 7'($urandom_range(count, 10 * count));
    end else begin
      req.subtask_count    = 4'($urandom_range(0, 15));
      req.difficulty_total = 7'($urandom_range(0, 127));
    end
    return req;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic compare_field(string field, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("deadline_priority_task_queue verification failed");
      $finish;
    end
  end

  // Driver: a transaction is taken at an edge with start high and busy low.
  bit launch;
  bit quiet_stretch;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      launch = !start;
      if (start && !busy) begin
        expected_results.push_back(queue_step(request));
        accepted_count++;
        launch = 1'b1;
      end
      quiet_stretch = accepted_count >= 250 && accepted_count < 350;
      if (launch) begin
        if (pending_requests.size() != 0 &&
            (quiet_stretch || $urandom_range(0, 99) >= 10)) begin
          request <= pending_requests.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so every done cycle is checked.
  result_t want;
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no transaction outstanding");
      end else begin
        want = expected_results.pop_front();
        status_tally[want.status]++;
        compare_field("status", 16'(result.status), 16'(want.status));
        compare_field("out_tag", result.out_tag, want.out_tag);
        compare_field("out_day", 16'(result.out_day), 16'(want.out_day));
        compare_field("out_month", 16'(result.out_month), 16'(want.out_month));
        compare_field("out_year", 16'(result.out_year), 16'(want.out_year));
        compare_field("out_total", 16'(result.out_total), 16'(want.out_total));
        compare_field("out_count", 16'(result.out_count), 16'(want.out_count));
        compare_field("fill_level", 16'(result.fill_level), 16'(want.fill_level));
      end
    end
  end

  int mix_pct[3] = '{95, 55, 10};
  int queued;
  int round_idx;
  initial begin
    // Directed: empty queue, field extremes, equal dates and averages.
    pending_requests.push_back(removal());
    pending_requests.push_back(insert_of(16'hFFFF, 5'd31, 4'd12, 14'd9999, 7'd100, 4'd10));
    pending_requests.push_back(insert_of(16'h0000, 5'd1, 4'd1, 14'd2023, 7'd0, 4'd0));
    pending_requests.push_back(insert_of(16'h0001, 5'd1, 4'd1, 14'd2023, 7'd50, 4'd0));
    pending_requests.push_back(insert_of(16'h0002, 5'd1, 4'd1, 14'd2023, 7'd5, 4'd1));
    pending_requests.push_back(insert_of(16'h0003, 5'd1, 4'd1, 14'd2023, 7'd10, 4'd2));
    pending_requests.push_back(insert_of(16'h0004, 5'd1, 4'd1, 14'd2023, 7'd127, 4'd15));
    pending_requests.push_back(insert_of(16'h5555, 5'd0, 4'd0, 14'd0, 7'd1, 4'd1));
    pending_requests.push_back(insert_of(16'hAAAA, 5'd31, 4'd15, 14'd16383, 7'd127, 4'd15));
    pending_requests.push_back(insert_of(16'h0005, 5'd31, 4'd12, 14'd9999, 7'd0, 4'd0));
    pending_requests.push_back(insert_of(16'h0006, 5'd31, 4'd12, 14'd9999, 7'd100, 4'd10));
    repeat (11) pending_requests.push_back(removal());

    // Random rounds alternate between filling past capacity, a balanced
    // mix, and draining past empty.
    queued = 0;
    round_idx = 0;
    while (queued < RANDOM_ITEMS) begin
      repeat (ROUND_LENGTH) begin
        if ($urandom_range(0, 99) < mix_pct[round_idx % 3])
          pending_requests.push_back(random_insert());
        else
          pending_requests.push_back(removal());
        queued++;
      end
      round_idx++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      report_mismatch("expected result never arrived");
    end

    $display("Covered %0d transactions: %0d inserted, %0d dropped on a full queue,",
             accepted_count, status_tally[ST_INSERTED], status_tally[ST_FULL]);
    $display("%0d removed, %0d removals from an empty queue; peak fill %0d of %0d.",
             status_tally[ST_REMOVED], status_tally[ST_EMPTY], peak_fill, QUEUE_DEPTH);
    if (error_count == 0) begin
      $display("deadline_priority_task_queue verification clean");
    end else begin
      $display("deadline_priority_task_queue verification failed");
    end
    $finish;
  end

endmodule
